>>> rtl/bmhq_pkg.sv
package bmhq_pkg;

	// Fixed widths of the request and result fields.
	localparam int unsigned VAL_W = 31;
	localparam int unsigned CNT_W = 11;

	// Request operation codes.
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// One request beat.
	typedef struct packed {
		logic             operation;
		logic [VAL_W-1:0] value;
	} req_t;

	// One result beat.
	typedef struct packed {
		logic [1:0]       status;
		logic [VAL_W-1:0] max_value;
		logic [CNT_W-1:0] count;
	} rsp_t;

	// Heap position whose store slot the read port addresses.
	typedef enum logic [2:0] {
		RA_ROOT,
		RA_TAIL,
		RA_PARENT,
		RA_LEFT,
		RA_RIGHT
	} rd_sel_t;

	// Source of the word written at the current position.
	typedef enum logic [1:0] {
		WD_KEY,
		WD_RDATA,
		WD_CHILD
	} wr_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    latch;
		logic    set_status;
		status_t status;
		logic    push_init;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_en;
		wr_sel_t wr_sel;
		logic    cap_max;
		logic    pop_init;
		logic    pos_up;
		logic    cap_left;
		logic    cap_right;
		logic    pos_down;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic op_pop;
		logic full;
		logic empty;
		logic pos_is_root;
		logic no_left;
		logic has_right;
		logic key_gt_rd;
		logic rd_gt_child;
		logic key_lt_child;
	} flags_t;

endpackage

>>> rtl/binary_max_heap_queue_unit.sv
// Binary max-heap priority queue.
//
// Request channel: drive req and raise start; the beat is taken at a rising
// edge where start is high and busy is low. A push (operation 0) inserts
// req.value, a pop (operation 1) removes and returns the largest key held.
// Result channel: done is high for exactly one cycle and rsp carries the
// status, the popped key (zero unless a pop succeeded) and the entry count
// after the operation. The receiver cannot stall; every request gives one
// result beat, and a new request may be taken in the cycle done is high.
//
// Steps: a refused push or an empty pop finishes at the decode step. A
// push climbs one level per parent fetch and compare; a pop fetches the
// root and the tail, then descends one level per fetch of the children
// and compare, with the single store port (one read, one write, registered
// read data) setting the pace.
//
// Reset clears the entry count and the controller; the store itself is not
// cleared, since only positions already written are ever read.
module binary_max_heap_queue_unit import bmhq_pkg::*; #(
	parameter int unsigned CAPACITY   = 1024,
	parameter int unsigned VALUE_BITS = 31
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	cmd_t   cmd;
	flags_t flags;

	bmhq_controller u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.flags  (flags),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	bmhq_datapath #(
		.CAPACITY   (CAPACITY),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.flags  (flags),
		.rsp    (rsp)
	);

endmodule

>>> rtl/bmhq_ram.sv
module bmhq_ram #(
	parameter int unsigned WIDTH = 31,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/bmhq_datapath.sv
module bmhq_datapath import bmhq_pkg::*; #(
	parameter int unsigned CAPACITY   = 1024,
	parameter int unsigned VALUE_BITS = 31
) (
	input  logic   clk,
	input  logic   arst_n,
	input  req_t   req,
	input  cmd_t   cmd,
	output flags_t flags,
	output rsp_t   rsp
);

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned PW = $clog2(CAPACITY + 1);

	logic                  op_q;
	logic [VALUE_BITS-1:0] key_q;
	logic [VALUE_BITS-1:0] child_q;
	logic [VALUE_BITS-1:0] max_q;
	logic [PW-1:0]         pos_q;
	logic [PW-1:0]         big_q;
	logic [PW-1:0]         count_q;
	status_t               status_q;

	logic [PW:0]           left_pos;
	logic [PW:0]           right_pos;
	logic [PW:0]           count_ext;
	logic [PW-1:0]         next_count;
	logic [AW-1:0]         raddr;
	logic [AW-1:0]         waddr;
	logic [VALUE_BITS-1:0] wdata;
	logic [VALUE_BITS-1:0] rdata;

	// Child positions of the current position, one bit wider than a position.
	assign left_pos   = {pos_q, 1'b0};
	assign right_pos  = left_pos + 1'b1;
	assign count_ext  = {1'b0, count_q};
	assign next_count = count_q + 1'b1;

	// Heap position p lives in store slot p - 1.
	always_comb begin
		case (cmd.rd_sel)
			RA_ROOT:   raddr = '0;
			RA_TAIL:   raddr = AW'(count_q - 1'b1);
			RA_PARENT: raddr = AW'((pos_q >> 1) - 1'b1);
			RA_LEFT:   raddr = AW'(left_pos - 1'b1);
			RA_RIGHT:  raddr = AW'(left_pos);
			default:   raddr = '0;
		endcase
	end

	assign waddr = AW'(pos_q - 1'b1);

	always_comb begin
		case (cmd.wr_sel)
			WD_KEY:   wdata = key_q;
			WD_RDATA: wdata = rdata;
			WD_CHILD: wdata = child_q;
			default:  wdata = key_q;
		endcase
	end

	bmhq_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (cmd.wr_en),
		.waddr (waddr),
		.wdata (wdata),
		.re    (cmd.rd_en),
		.raddr (raddr),
		.rdata (rdata)
	);

	// The entry count is the only control state here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.push_init) begin
			count_q <= next_count;
		end else if (cmd.pop_init) begin
			count_q <= count_q - 1'b1;
		end
	end

	// Working registers of the current operation.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q     <= req.operation;
			key_q    <= VALUE_BITS'(req.value);
			max_q    <= '0;
			status_q <= ST_OK;
		end
		if (cmd.set_status) begin
			status_q <= cmd.status;
		end
		if (cmd.push_init) begin
			pos_q <= next_count;
		end
		if (cmd.cap_max) begin
			max_q <= rdata;
		end
		if (cmd.pop_init) begin
			key_q <= rdata;
			pos_q <= PW'(1);
		end
		if (cmd.pos_up) begin
			pos_q <= pos_q >> 1;
		end
		if (cmd.cap_left) begin
			child_q <= rdata;
			big_q   <= PW'(left_pos);
		end
		if (cmd.cap_right) begin
			child_q <= rdata;
			big_q   <= PW'(right_pos);
		end
		if (cmd.pos_down) begin
			pos_q <= big_q;
		end
	end

	// Status toward the controller.
	assign flags.op_pop       = (op_q == OP_POP);
	assign flags.full         = (count_q == PW'(CAPACITY));
	assign flags.empty        = (count_q == '0);
	assign flags.pos_is_root  = (pos_q == PW'(1));
	assign flags.no_left      = (left_pos > count_ext);
	assign flags.has_right    = (right_pos <= count_ext);
	assign flags.key_gt_rd    = (key_q > rdata);
	assign flags.rd_gt_child  = (rdata > child_q);
	assign flags.key_lt_child = (key_q < child_q);

	// Result fields, valid while the controller strobes done.
	assign rsp.status    = status_q;
	assign rsp.max_value = VAL_W'(max_q);
	assign rsp.count     = CNT_W'(count_q);

	// The entry count never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= PW'(CAPACITY))
		else $error("entry count above capacity");

	// Writes always land on a real heap position.
	a_write_pos: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> (pos_q != '0) && (pos_q <= PW'(CAPACITY)))
		else $error("store write outside the heap");

endmodule

>>> rtl/bmhq_controller.sv
module bmhq_controller import bmhq_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  flags_t flags,
	output logic   busy,
	output logic   done,
	output cmd_t   cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_UP_CHECK,
		S_UP_CMP,
		S_POP_ROOT,
		S_POP_TAIL,
		S_DN_CHECK,
		S_DN_LEFT,
		S_DN_RIGHT,
		S_DN_CMP
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   done_q;
	logic   finish;

	// Step decode: commands and next state.
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		finish  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_d   = S_DECODE;
				end
			end
			S_DECODE: begin
				if (!flags.op_pop) begin
					if (flags.full) begin
						cmd.set_status = 1'b1;
						cmd.status     = ST_FULL;
						finish         = 1'b1;
					end else begin
						cmd.push_init = 1'b1;
						state_d       = S_UP_CHECK;
					end
				end else if (flags.empty) begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_EMPTY;
					finish         = 1'b1;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_ROOT;
					state_d    = S_POP_ROOT;
				end
			end
			// Sift up: fetch the parent unless the hole is at the root.
			S_UP_CHECK: begin
				if (flags.pos_is_root) begin
					cmd.wr_en  = 1'b1;
					cmd.wr_sel = WD_KEY;
					finish     = 1'b1;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_PARENT;
					state_d    = S_UP_CMP;
				end
			end
			// A smaller parent moves down into the hole.
			S_UP_CMP: begin
				cmd.wr_en = 1'b1;
				if (flags.key_gt_rd) begin
					cmd.wr_sel = WD_RDATA;
					cmd.pos_up = 1'b1;
					state_d    = S_UP_CHECK;
				end else begin
					cmd.wr_sel = WD_KEY;
					finish     = 1'b1;
				end
			end
			S_POP_ROOT: begin
				cmd.cap_max = 1'b1;
				cmd.rd_en   = 1'b1;
				cmd.rd_sel  = RA_TAIL;
				state_d     = S_POP_TAIL;
			end
			S_POP_TAIL: begin
				cmd.pop_init = 1'b1;
				state_d      = S_DN_CHECK;
			end
			// Sift down: stop at a leaf, else fetch the children.
			S_DN_CHECK: begin
				if (flags.no_left) begin
					cmd.wr_en  = 1'b1;
					cmd.wr_sel = WD_KEY;
					finish     = 1'b1;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_LEFT;
					state_d    = S_DN_LEFT;
				end
			end
			S_DN_LEFT: begin
				cmd.cap_left = 1'b1;
				if (flags.has_right) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_RIGHT;
					state_d    = S_DN_RIGHT;
				end else begin
					state_d = S_DN_CMP;
				end
			end
			// The right child wins only when strictly larger.
			S_DN_RIGHT: begin
				cmd.cap_right = flags.rd_gt_child;
				state_d       = S_DN_CMP;
			end
			// A larger child moves up into the hole.
			S_DN_CMP: begin
				cmd.wr_en = 1'b1;
				if (flags.key_lt_child) begin
					cmd.wr_sel   = WD_CHILD;
					cmd.pos_down = 1'b1;
					state_d      = S_DN_CHECK;
				end else begin
					cmd.wr_sel = WD_KEY;
					finish     = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (finish) begin
			state_d = S_IDLE;
		end
	end

	// State and the result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= finish;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	// The result beat appears only once the block is free again.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// An accepted request always occupies the block next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy && !done)
		else $error("accepted request did not start");

	// Each operation gives a single result beat.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

endmodule
